// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros for the RTL of the pair potential core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("Assertion failed.");
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("Forbidden condition seen.");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

// ===== hw/rtl/lj_pkg.sv =====
// ----------------------------------------------------------------------------
// lj_pkg
// Types, constants and fixed point helpers of the pair potential core.
// ----------------------------------------------------------------------------
package lj_pkg;

  localparam int NUM_SPECIES_DEF    = 4;
  localparam int DIST_FRAC_BITS_DEF = 16;

  localparam int FIELD_W  = 24;
  localparam int SPEC_W   = 2;
  localparam int OUT_W    = 48;
  localparam int POW_W    = 63;
  localparam int QUO_W    = FIELD_W + 32;
  localparam int DIV_STEP = 2;
  localparam int DIV_STAGES = QUO_W / DIV_STEP;
  localparam int POW_LAT  = DIV_STAGES + 8;
  localparam int CORE_LAT = POW_LAT + 7;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;

  localparam logic [POW_W-1:0] POW_CAP = {1'b1, {(POW_W-1){1'b0}}};
  localparam logic [OUT_W-1:0] POS_LIMIT = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] NEG_LIMIT = {1'b1, {(OUT_W-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] REG_CORE_RADIUS_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CORE_CONST_MODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_ENABLE     = 2'd2;

  localparam logic [1:0] CORE_SIGMA     = 2'd0;
  localparam logic [1:0] CORE_MINIMUM   = 2'd1;
  localparam logic [1:0] CORE_ZERO      = 2'd2;
  localparam logic [1:0] CORE_SIGMA_MIN = 2'd3;

  localparam logic OP_EVALUATE = 1'b0;
  localparam logic OP_LOAD     = 1'b1;

  typedef struct packed {
    logic               valid;
    logic               zero;
    logic               shift;
    logic [FIELD_W-1:0] eps;
  } side_t;

  typedef struct packed {
    logic [61:0] hh;
    logic [62:0] hl;
    logic [62:0] lh;
    logic [63:0] ll;
  } pp_t;

  function automatic pp_t qmul_pp(input logic [POW_W-1:0] a, input logic [POW_W-1:0] b);
    pp_t p;
    p.hh = 62'(a[62:32]) * 62'(b[62:32]);
    p.hl = 63'(a[62:32]) * 63'(b[31:0]);
    p.lh = 63'(a[31:0]) * 63'(b[62:32]);
    p.ll = 64'(a[31:0]) * 64'(b[31:0]);
    return p;
  endfunction

  function automatic logic [POW_W-1:0] qmul_sum(input pp_t p);
    logic [64:0] sum;
    sum = (65'(p.hh) << 32) + 65'(p.hl) + 65'(p.lh) + 65'(p.ll >> 32);
    if (p.hh >= 62'(64'd1 << 30)) begin
      return POW_CAP;
    end
    if (sum > 65'(POW_CAP)) begin
      return POW_CAP;
    end
    return sum[POW_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/lj_pow.sv =====
// ----------------------------------------------------------------------------
// lj_pow
// Pipelined sixth and twelfth powers of s/r in Q.32: a radix-2 restoring
// divider followed by four two-stage capped multiplications.
// ----------------------------------------------------------------------------
module lj_pow (
  input  logic                       clk,
  input  logic [lj_pkg::FIELD_W-1:0] s,
  input  logic [lj_pkg::FIELD_W-1:0] r,
  output logic [lj_pkg::POW_W-1:0]   x6,
  output logic [lj_pkg::POW_W-1:0]   x12
);

  localparam int FW = lj_pkg::FIELD_W;
  localparam int QW = lj_pkg::QUO_W;
  localparam int DS = lj_pkg::DIV_STAGES;

  logic [FW-1:0] rem_q [DS];
  logic [QW-1:0] num_q [DS];
  logic [QW-1:0] quo_q [DS];
  logic [FW-1:0] dvs_q [DS];
  logic          rz_q  [DS];

  for (genvar k = 0; k < DS; k++) begin : g_div
    logic [FW-1:0] rem_i, dvs_i, rem_o;
    logic [QW-1:0] num_i, quo_i, num_o, quo_o;
    logic          rz_i;
    logic [FW:0]   t;
    if (k == 0) begin : g_first
      assign rem_i = '0;
      assign num_i = {s, 32'b0};
      assign quo_i = '0;
      assign dvs_i = r;
      assign rz_i  = (r == '0);
    end else begin : g_next
      assign rem_i = rem_q[k-1];
      assign num_i = num_q[k-1];
      assign quo_i = quo_q[k-1];
      assign dvs_i = dvs_q[k-1];
      assign rz_i  = rz_q[k-1];
    end
    always_comb begin
      rem_o = rem_i;
      num_o = num_i;
      quo_o = quo_i;
      t     = '0;
      for (int j = 0; j < lj_pkg::DIV_STEP; j++) begin
        t     = {rem_o, num_o[QW-1]};
        num_o = {num_o[QW-2:0], 1'b0};
        if (t >= {1'b0, dvs_i}) begin
          t     = t - {1'b0, dvs_i};
          quo_o = {quo_o[QW-2:0], 1'b1};
        end else begin
          quo_o = {quo_o[QW-2:0], 1'b0};
        end
        rem_o = t[FW-1:0];
      end
    end
    always_ff @(posedge clk) begin
      rem_q[k] <= rem_o;
      num_q[k] <= num_o;
      quo_q[k] <= quo_o;
      dvs_q[k] <= dvs_i;
      rz_q[k]  <= rz_i;
    end
  end

  logic [lj_pkg::POW_W-1:0] q;
  logic [lj_pkg::POW_W-1:0] q2, q2d1, q2d2, q4, x6r, x6d;
  lj_pkg::pp_t pp1, pp2, pp3, pp4;

  assign q = rz_q[DS-1] ? lj_pkg::POW_CAP : lj_pkg::POW_W'(quo_q[DS-1]);

  always_ff @(posedge clk) begin
    pp1  <= lj_pkg::qmul_pp(q, q);
    q2   <= lj_pkg::qmul_sum(pp1);
    pp2  <= lj_pkg::qmul_pp(q2, q2);
    q2d1 <= q2;
    q4   <= lj_pkg::qmul_sum(pp2);
    q2d2 <= q2d1;
    pp3  <= lj_pkg::qmul_pp(q4, q2d2);
    x6r  <= lj_pkg::qmul_sum(pp3);
    pp4  <= lj_pkg::qmul_pp(x6r, x6r);
    x6d  <= x6r;
    x12  <= lj_pkg::qmul_sum(pp4);
    x6   <= x6d;
  end

endmodule

// ===== hw/rtl/lj_attractive_pair_potential_core.sv =====
// ----------------------------------------------------------------------------
// lj_attractive_pair_potential_core
// Attractive 12-6 Lennard-Jones pair potential with per-pair tables, core
// handling and optional cut and shift, in saturating fixed point.
// ----------------------------------------------------------------------------
// A word is taken on every cycle in which start is high; busy is always low,
// so a new word may follow in the very next cycle. Every word, load or
// evaluate, yields exactly one result word on done, whatever came before;
// the receiver cannot stall it. The latency is set by the 28-stage divider
// and the four two-stage multiplications of the power chain, run in parallel
// for the distance and the cutoff. A load is visible to an evaluate taken in
// the next cycle.
`include "assert_macros.svh"

module lj_attractive_pair_potential_core #(
  parameter int DIST_FRAC_BITS = lj_pkg::DIST_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          operation,
  input  logic [lj_pkg::SPEC_W-1:0]     species_a,
  input  logic [lj_pkg::SPEC_W-1:0]     species_b,
  input  logic [lj_pkg::FIELD_W-1:0]    distance,
  input  logic [lj_pkg::FIELD_W-1:0]    load_sigma,
  input  logic [lj_pkg::FIELD_W-1:0]    load_epsilon,
  input  logic [lj_pkg::FIELD_W-1:0]    load_cutoff,
  input  logic [lj_pkg::FIELD_W-1:0]    load_min_radius,
  input  logic [lj_pkg::FIELD_W-1:0]    load_zero_radius,
  input  logic                          cfg_write,
  input  logic [lj_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lj_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                          done,
  output logic signed [lj_pkg::OUT_W-1:0] potential,
  output logic                          saturated
);

  localparam int NUM_SPECIES = lj_pkg::NUM_SPECIES_DEF;
  localparam int FW    = lj_pkg::FIELD_W;
  localparam int DEPTH = NUM_SPECIES * NUM_SPECIES;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PL    = lj_pkg::POW_LAT;

  // Configuration registers.
  logic [1:0] core_radius_mode;
  logic       core_const_mode;
  logic       shift_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      core_radius_mode <= lj_pkg::CORE_SIGMA;
      core_const_mode  <= 1'b1;
      shift_enable     <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        lj_pkg::REG_CORE_RADIUS_MODE: core_radius_mode <= cfg_data[1:0];
        lj_pkg::REG_CORE_CONST_MODE:  core_const_mode  <= cfg_data[0];
        lj_pkg::REG_SHIFT_ENABLE:     shift_enable     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Pair tables.
  logic [FW-1:0] sigma_table      [DEPTH];
  logic [FW-1:0] epsilon_table    [DEPTH];
  logic [FW-1:0] cutoff_table     [DEPTH];
  logic [FW-1:0] min_radius_table [DEPTH];
  logic [FW-1:0] zero_radius_table[DEPTH];

  logic          accept, in_range;
  logic [7:0]    idx_full;
  logic [IDX_W-1:0] idx;

  assign accept   = start && !busy;
  assign in_range = (32'(species_a) < NUM_SPECIES) && (32'(species_b) < NUM_SPECIES);
  assign idx_full = 8'(species_a) * 8'(NUM_SPECIES) + 8'(species_b);
  assign idx      = idx_full[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (accept && in_range && operation == lj_pkg::OP_LOAD) begin
      sigma_table[idx]       <= load_sigma;
      epsilon_table[idx]     <= load_epsilon;
      cutoff_table[idx]      <= load_cutoff;
      min_radius_table[idx]  <= load_min_radius;
      zero_radius_table[idx] <= load_zero_radius;
    end
  end

  // Stage 0: input word and table read.
  logic          v0, eval0;
  logic [FW-1:0] r0, sig0, eps0, cut0, min0, zr0;

  always_ff @(posedge clk) begin
    eval0 <= in_range && operation == lj_pkg::OP_EVALUATE;
    r0    <= distance;
    sig0  <= in_range ? sigma_table[idx] : '0;
    eps0  <= in_range ? epsilon_table[idx] : '0;
    cut0  <= in_range ? cutoff_table[idx] : '0;
    min0  <= in_range ? min_radius_table[idx] : '0;
    zr0   <= in_range ? zero_radius_table[idx] : '0;
    v0    <= accept && !rst;
  end

  // Stage 1: core and cutoff decisions.
  logic [FW-1:0] core0, reff0;
  logic          zero0;
  lj_pkg::side_t s1;
  logic [FW-1:0] sig1, r1, cut1;

  always_comb begin
    case (core_radius_mode)
      lj_pkg::CORE_SIGMA: core0 = sig0;
      lj_pkg::CORE_ZERO:  core0 = zr0;
      default:            core0 = min0;
    endcase
    reff0 = (r0 < core0) ? core0 : r0;
    zero0 = !eval0 || (r0 < core0 && core_const_mode) ||
            (r0 < sig0 && core_radius_mode == lj_pkg::CORE_SIGMA_MIN) ||
            (shift_enable && r0 > cut0) || (eps0 == '0);
  end

  always_ff @(posedge clk) begin
    s1.valid <= v0 && !rst;
    s1.zero  <= zero0;
    s1.shift <= shift_enable;
    s1.eps   <= eps0;
    sig1     <= sig0;
    r1       <= reff0;
    cut1     <= cut0;
  end

  // Power chains for the distance and for the cutoff.
  logic [lj_pkg::POW_W-1:0] x6, x12, c6, c12;

  lj_pow u_pow_dist (.clk(clk), .s(sig1), .r(r1),   .x6(x6), .x12(x12));
  lj_pow u_pow_cut  (.clk(clk), .s(sig1), .r(cut1), .x6(c6), .x12(c12));

  lj_pkg::side_t sd [PL];

  for (genvar k = 0; k < PL; k++) begin : g_side
    lj_pkg::side_t sd_in;
    if (k == 0) begin : g_head
      assign sd_in = s1;
    end else begin : g_tail
      assign sd_in = sd[k-1];
    end
    always_ff @(posedge clk) begin
      sd[k] <= rst ? '0 : sd_in;
    end
  end

  // Stages B1 to B4: overflow checks, bracket sums, their signed difference and the product with four times epsilon.
  lj_pkg::side_t b1, b2, b3, b4;
  logic          b1_psat, b1_nsat, b2_psat, b2_nsat, b3_psat, b3_nsat;
  logic          b4_psat, b4_nsat, b2_neg, b3_neg, b4_neg, b4_hsat;
  logic [63:0]   b1_pos, b1_negv;
  logic [62:0]   b2_mag;
  logic [56:0]   b3_hp;
  logic [57:0]   b3_lo;
  logic [63:0]   b4_v;
  logic [25:0]   e4;

  assign e4 = {b2.eps, 2'b00};

  always_ff @(posedge clk) begin
    b1      <= rst ? '0 : sd[PL-1];
    b1_psat <= (x12 >= lj_pkg::POW_CAP);
    b1_nsat <= sd[PL-1].shift && (c12 >= lj_pkg::POW_CAP);
    b1_pos  <= 64'(x12) + (sd[PL-1].shift ? 64'(c6) : 64'd0);
    b1_negv <= 64'(x6) + (sd[PL-1].shift ? 64'(c12) : 64'd0);

    b2      <= rst ? '0 : b1;
    b2_psat <= b1_psat;
    b2_nsat <= b1_nsat;
    b2_neg  <= (b1_negv > b1_pos);
    b2_mag  <= (b1_negv > b1_pos) ? 63'(b1_negv - b1_pos) : 63'(b1_pos - b1_negv);

    b3      <= rst ? '0 : b2;
    b3_psat <= b2_psat;
    b3_nsat <= b2_nsat;
    b3_neg  <= b2_neg;
    b3_hp   <= 57'(b2_mag[62:32]) * 57'(e4);
    b3_lo   <= 58'(b2_mag[31:0]) * 58'(e4);

    b4      <= rst ? '0 : b3;
    b4_psat <= b3_psat;
    b4_nsat <= b3_nsat;
    b4_neg  <= b3_neg;
    b4_hsat <= (b3_hp >= 57'(64'd1 << (15 + DIST_FRAC_BITS)));
    b4_v    <= (64'(b3_hp) << (32 - DIST_FRAC_BITS)) + 64'(b3_lo >> DIST_FRAC_BITS);
  end

  // Output stage: sign and saturation.
  logic [lj_pkg::OUT_W-1:0] pot_next;
  logic                     sat_next;

  always_comb begin
    pot_next = '0;
    sat_next = 1'b0;
    if (b4.zero) begin
      pot_next = '0;
    end else if (b4_psat) begin
      pot_next = lj_pkg::POS_LIMIT;
      sat_next = 1'b1;
    end else if (b4_nsat) begin
      pot_next = lj_pkg::NEG_LIMIT;
      sat_next = 1'b1;
    end else if (b4_hsat ||
                 b4_v > (b4_neg ? 64'(lj_pkg::NEG_LIMIT) : 64'(lj_pkg::POS_LIMIT))) begin
      pot_next = b4_neg ? lj_pkg::NEG_LIMIT : lj_pkg::POS_LIMIT;
      sat_next = 1'b1;
    end else begin
      pot_next = b4_neg ? lj_pkg::OUT_W'(64'd0 - b4_v) : b4_v[lj_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    potential <= pot_next;
    saturated <= sat_next;
    done      <= b4.valid && !rst;
  end

  `ASSERT_PROP(a_latency, clk, rst, accept |-> ##(lj_pkg::CORE_LAT) done)
  `ASSERT_NEVER(a_sat_limit, clk, rst, done && saturated && potential != lj_pkg::POS_LIMIT && potential != lj_pkg::NEG_LIMIT)
  `ASSERT_PROP(a_zero_word, clk, rst, b4.valid && b4.zero |=> done && potential == '0 && !saturated)
  `ASSERT_NEVER(a_never_busy, clk, rst, busy)

endmodule
